[src/b64e_pkg.sv]
// ----------------------------------------------------------------------------
// b64e_pkg
// Shared types, constants and the character map of the base64 encoder.
// ----------------------------------------------------------------------------
package b64e_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned TripleW   = 3 * ByteW;
  localparam int unsigned SextetW   = 6;
  localparam int unsigned PadW      = 2;
  localparam int unsigned QueueDepth = 2;

  localparam logic [ByteW-1:0] PAD_CHAR = 8'h3D;

  // one 24-bit group waiting to be turned into four characters
  typedef struct packed {
    logic [TripleW-1:0] triple;
    logic [PadW-1:0]    pads;
    logic               msg_end;
  } grp_t;

  localparam int unsigned GrpW = $bits(grp_t);

  // standard alphabet: A-Z, a-z, 0-9, '+', '/'
  function automatic logic [ByteW-1:0] sextet_char(input logic [SextetW-1:0] idx);
    logic [ByteW-1:0] wide_idx;
    logic [ByteW-1:0] ch;
    wide_idx = {{(ByteW-SextetW){1'b0}}, idx};
    if (idx < 6'd26) begin
      ch = 8'h41 + wide_idx;
    end else if (idx < 6'd52) begin
      ch = 8'h61 + wide_idx - 8'd26;
    end else if (idx < 6'd62) begin
      ch = 8'h30 + wide_idx - 8'd52;
    end else if (idx == 6'd62) begin
      ch = 8'h2B;
    end else begin
      ch = 8'h2F;
    end
    return ch;
  endfunction

endpackage

[src/b64e_front.sv]
// ----------------------------------------------------------------------------
// b64e_front
// Collects input bytes into 24-bit groups and pushes finished groups and the
// short group that closes a message.
module b64e_front
  import b64e_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [ByteW-1:0] in_data_byte,
  input  logic             in_last_byte,
  output logic             push,
  output grp_t             push_grp,
  input  logic             q_full
);

  logic [2*ByteW-1:0] held_r, held_nxt;
  logic [1:0]         cnt_r, cnt_nxt;
  logic               acc;

  assign in_stall = q_full;
  assign acc      = in_valid && !q_full;

  always_comb begin
    held_nxt = held_r;
    cnt_nxt  = cnt_r;
    push     = 1'b0;
    push_grp = '0;
    if (acc) begin
      case (cnt_r)
        2'd0: begin
          if (in_last_byte) begin
            push             = 1'b1;
            push_grp.triple  = {in_data_byte, {(2*ByteW){1'b0}}};
            push_grp.pads    = 2'd2;
            push_grp.msg_end = 1'b1;
          end else begin
            held_nxt = {{ByteW{1'b0}}, in_data_byte};
            cnt_nxt  = 2'd1;
          end
        end
        2'd1: begin
          if (in_last_byte) begin
            push             = 1'b1;
            push_grp.triple  = {held_r[ByteW-1:0], in_data_byte, {ByteW{1'b0}}};
            push_grp.pads    = 2'd1;
            push_grp.msg_end = 1'b1;
            held_nxt         = '0;
            cnt_nxt          = 2'd0;
          end else begin
            held_nxt = {held_r[ByteW-1:0], in_data_byte};
            cnt_nxt  = 2'd2;
          end
        end
        default: begin
          push             = 1'b1;
          push_grp.triple  = {held_r, in_data_byte};
          push_grp.pads    = 2'd0;
          push_grp.msg_end = in_last_byte;
          held_nxt         = '0;
          cnt_nxt          = 2'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
      cnt_r  <= '0;
    end else begin
      held_r <= held_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

[src/b64e_queue.sv]
// ----------------------------------------------------------------------------
// b64e_queue
// Short group queue between the byte collector and the character stage.
// ----------------------------------------------------------------------------
module b64e_queue
  import b64e_pkg::*;
#(
  parameter int unsigned Depth = QueueDepth
)
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  grp_t push_grp,
  output logic full,
  input  logic pop,
  output logic not_empty,
  output grp_t head_grp
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  grp_t            mem_r [Depth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign full      = (cnt_r == CntW'(Depth));
  assign not_empty = (cnt_r != '0);
  assign head_grp  = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_grp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

[src/b64e_back.sv]
// ----------------------------------------------------------------------------
// b64e_back
// Walks the head group a sextet a cycle into a char register unless stalled.
// ----------------------------------------------------------------------------
module b64e_back
  import b64e_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_not_empty,
  input  grp_t             q_head,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [ByteW-1:0] out_code_char,
  output logic             out_group_last,
  output logic             out_message_end
);

  logic [1:0]         pos_r, pos_nxt;
  logic               vld_r, vld_nxt;
  logic [ByteW-1:0]   char_r, char_nxt;
  logic               glast_r, glast_nxt;
  logic               mend_r, mend_nxt;
  logic               load;
  logic [SextetW-1:0] sextet;
  logic               is_pad;

  assign load = !vld_r || !out_stall;

  always_comb begin
    case (pos_r)
      2'd0:    sextet = q_head.triple[23:18];
      2'd1:    sextet = q_head.triple[17:12];
      2'd2:    sextet = q_head.triple[11:6];
      default: sextet = q_head.triple[5:0];
    endcase
  end

  // two pads cover the last two places, one pad only the last
  assign is_pad = ((q_head.pads == 2'd2) && pos_r[1]) ||
                  ((q_head.pads == 2'd1) && (pos_r == 2'd3));

  always_comb begin
    pos_nxt   = pos_r;
    vld_nxt   = vld_r;
    char_nxt  = char_r;
    glast_nxt = glast_r;
    mend_nxt  = mend_r;
    pop       = 1'b0;
    if (load) begin
      vld_nxt = q_not_empty;
      if (q_not_empty) begin
        char_nxt  = is_pad ? PAD_CHAR : sextet_char(sextet);
        glast_nxt = (pos_r == 2'd3);
        mend_nxt  = (pos_r == 2'd3) && q_head.msg_end;
        pos_nxt   = pos_r + 1'b1;
        pop       = (pos_r == 2'd3);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      vld_r <= 1'b0;
    end else begin
      pos_r <= pos_nxt;
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    char_r  <= char_nxt;
    glast_r <= glast_nxt;
    mend_r  <= mend_nxt;
  end

  assign out_valid       = vld_r;
  assign out_code_char   = char_r;
  assign out_group_last  = glast_r;
  assign out_message_end = mend_r;

endmodule

[src/base64_stream_encoder.sv]
// ----------------------------------------------------------------------------
// base64_stream_encoder
// Streaming base64 encoder, standard alphabet with '=' padding.
// ----------------------------------------------------------------------------
// One raw byte per input word, with a flag on the final byte of a message.
// Bytes collect into 24-bit groups; each finished group (or the short group
// that closes a message) enters a queue of QDepth groups and leaves as
// four characters, one per output word, with group_last on the fourth and
// message_end on the fourth of the closing group. The character stage gives
// one character per cycle while out_stall does not hold it; a full group
// makes four characters from three bytes. Input bytes are taken every cycle
// until the queue is full. A completing byte's group is registered in the
// queue, and its first character is then registered in the character stage.
module base64_stream_encoder
  import b64e_pkg::*;
#(
  parameter int unsigned QDepth = QueueDepth
)
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [ByteW-1:0] in_data_byte,
  input  logic             in_last_byte,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [ByteW-1:0] out_code_char,
  output logic             out_group_last,
  output logic             out_message_end
);

  logic push, pop, q_full, q_not_empty;
  grp_t push_grp, head_grp;

  b64e_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .push         (push),
    .push_grp     (push_grp),
    .q_full       (q_full)
  );

  b64e_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_grp  (push_grp),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .head_grp  (head_grp)
  );

  b64e_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_not_empty     (q_not_empty),
    .q_head          (head_grp),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_code_char   (out_code_char),
    .out_group_last  (out_group_last),
    .out_message_end (out_message_end)
  );

endmodule
